// ----- src/arc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_pkg: shared types and constants of the arp reply cache
// operation and status codes, register indexes, controller/datapath structs
// ----------------------------------------------------------------------------
package arc_pkg;

	localparam int MAC_W    = 48;
	localparam int IP_W     = 32;
	localparam int OPC_W    = 16;
	localparam int TICK_W   = 16;
	localparam int CFG_IX_W = 1;

	typedef logic [1:0]          op_code_t;
	typedef logic [CFG_IX_W-1:0] cfg_idx_t;

	localparam op_code_t OP_PACKET = 2'd0;
	localparam op_code_t OP_LOOKUP = 2'd1;
	localparam op_code_t OP_TICK   = 2'd2;

	localparam logic [OPC_W-1:0]  ARP_OPCODE_REPLY = 16'd2;
	localparam logic [TICK_W-1:0] TIMEOUT_RESET    = 16'd2000;
	localparam logic [TICK_W-1:0] TICK_MAX         = 16'hFFFF;

	localparam cfg_idx_t CFG_OWN_MAC = 1'b0;
	localparam cfg_idx_t CFG_TIMEOUT = 1'b1;

	typedef enum logic [2:0] {
		ST_HIT      = 3'd0,
		ST_MISS     = 3'd1,
		ST_RESOLVED = 3'd2,
		ST_TIMEOUT  = 3'd3,
		ST_BUSY     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		MAC_ZERO,
		MAC_SENDER,
		MAC_CACHE
	} mac_sel_t;

	typedef enum logic [1:0] {
		IP_ZERO,
		IP_KEY,
		IP_SENDER,
		IP_PENDING
	} ip_sel_t;

	typedef enum logic {
		S_IDLE,
		S_SEARCH
	} state_t;

	typedef struct packed {
		op_code_t          operation;
		logic [OPC_W-1:0]  arp_opcode;
		logic [MAC_W-1:0]  sender_mac;
		logic [IP_W-1:0]   sender_ip;
		logic [IP_W-1:0]   target_ip;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [MAC_W-1:0] resolved_mac;
		logic [IP_W-1:0]  request_target_ip;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic     store;
		logic     start;
		logic     step;
		logic     set_pending;
		logic     clr_pending;
		logic     tick;
		logic     out_load;
		status_t  out_status;
		mac_sel_t mac_sel;
		ip_sel_t  ip_sel;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		op_code_t operation;
		logic     is_reply;
		logic     pending;
		logic     sip_match;
		logic     tick_expire;
		logic     sweep_done;
		logic     cmp_valid;
		logic     cmp_hit;
	} sts_t;

endpackage

// ----- src/arc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_if: handshake channels of the arp reply cache
// request, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface arc_req_if;
	logic                       valid;
	logic                       ready;
	arc_pkg::op_code_t          operation;
	logic [arc_pkg::OPC_W-1:0]  arp_opcode;
	logic [arc_pkg::MAC_W-1:0]  sender_mac;
	logic [arc_pkg::IP_W-1:0]   sender_ip;
	logic [arc_pkg::IP_W-1:0]   target_ip;

	modport source (output valid, operation, arp_opcode, sender_mac, sender_ip, target_ip,
		input ready);
	modport sink (input valid, operation, arp_opcode, sender_mac, sender_ip, target_ip,
		output ready);
endinterface

interface arc_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [2:0]                 status;
	logic [arc_pkg::MAC_W-1:0]  resolved_mac;
	logic [arc_pkg::IP_W-1:0]   request_target_ip;

	modport source (output valid, status, resolved_mac, request_target_ip, input ready);
	modport sink (input valid, status, resolved_mac, request_target_ip, output ready);
endinterface

interface arc_cfg_if;
	logic                       valid;
	logic                       ready;
	arc_pkg::cfg_idx_t          index;
	logic [arc_pkg::MAC_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- src/arc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_dp: datapath of the arp reply cache
// circular entry store, sweep address/compare, pending wait, output word
// ----------------------------------------------------------------------------
module arc_dp #(
	parameter int CACHE_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  arc_pkg::req_t     req,
	input  arc_pkg::cmd_t     cmd,
	input  logic              cfg_we,
	input  arc_pkg::cfg_idx_t cfg_index,
	input  logic [47:0]       cfg_data,
	output arc_pkg::sts_t     sts,
	output arc_pkg::rsp_t     rsp
);
	import arc_pkg::*;

	localparam int ADDR_W = $clog2(CACHE_DEPTH);
	localparam int CNT_W  = $clog2(CACHE_DEPTH + 1);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CACHE_DEPTH - 1);
	localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(CACHE_DEPTH);

	logic [IP_W-1:0]   ip_mem  [CACHE_DEPTH];
	logic [MAC_W-1:0]  mac_mem [CACHE_DEPTH];

	logic [ADDR_W-1:0] wr_ptr_q, rd_addr_q, newest;
	logic [CNT_W-1:0]  fill_q, left_q;
	logic              cmp_valid_s1;
	logic [IP_W-1:0]   rd_ip_s1;
	logic [MAC_W-1:0]  rd_mac_s1;
	logic [IP_W-1:0]   key_q;
	logic              pending_q;
	logic [IP_W-1:0]   pending_ip_q;
	logic [TICK_W-1:0] wait_q, wait_inc, limit, timeout_q;
	rsp_t              rsp_q;

	// newest entry sits just behind the write pointer
	assign newest   = (wr_ptr_q == '0) ? LAST_ADDR : wr_ptr_q - ADDR_W'(1);
	assign wait_inc = (wait_q == TICK_MAX) ? wait_q : wait_q + TICK_W'(1);
	assign limit    = (timeout_q == '0) ? TICK_W'(1) : timeout_q;

	// entry store, registered read
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			ip_mem[wr_ptr_q]  <= req.sender_ip;
			mac_mem[wr_ptr_q] <= req.sender_mac;
		end
		rd_ip_s1  <= ip_mem[rd_addr_q];
		rd_mac_s1 <= mac_mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			fill_q       <= '0;
			rd_addr_q    <= '0;
			left_q       <= '0;
			cmp_valid_s1 <= 1'b0;
			pending_q    <= 1'b0;
			pending_ip_q <= '0;
			wait_q       <= '0;
			timeout_q    <= TIMEOUT_RESET;
		end else begin
			if (cmd.store) begin
				wr_ptr_q <= (wr_ptr_q == LAST_ADDR) ? '0 : wr_ptr_q + ADDR_W'(1);
				if (fill_q != FULL_CNT)
					fill_q <= fill_q + CNT_W'(1);
			end

			cmp_valid_s1 <= cmd.step && (left_q != '0);
			if (cmd.start) begin
				rd_addr_q <= newest;
				left_q    <= fill_q;
			end else if (cmd.step && (left_q != '0)) begin
				rd_addr_q <= (rd_addr_q == '0) ? LAST_ADDR : rd_addr_q - ADDR_W'(1);
				left_q    <= left_q - CNT_W'(1);
			end

			if (cmd.clr_pending) begin
				pending_q <= 1'b0;
				wait_q    <= '0;
			end else if (cmd.set_pending) begin
				pending_q    <= 1'b1;
				pending_ip_q <= key_q;
				wait_q       <= '0;
			end else if (cmd.tick) begin
				wait_q <= wait_inc;
			end

			// own mac writes are taken but not stored here; only the timeout register is written
			if (cfg_we && (cfg_index == CFG_TIMEOUT))
				timeout_q <= cfg_data[TICK_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start)
			key_q <= req.target_ip;
		if (cmd.out_load) begin
			rsp_q.status <= cmd.out_status;
			case (cmd.mac_sel)
				MAC_SENDER: rsp_q.resolved_mac <= req.sender_mac;
				MAC_CACHE:  rsp_q.resolved_mac <= rd_mac_s1;
				default:    rsp_q.resolved_mac <= '0;
			endcase
			case (cmd.ip_sel)
				IP_KEY:     rsp_q.request_target_ip <= key_q;
				IP_SENDER:  rsp_q.request_target_ip <= req.sender_ip;
				IP_PENDING: rsp_q.request_target_ip <= pending_ip_q;
				default:    rsp_q.request_target_ip <= '0;
			endcase
		end
	end

	assign rsp = rsp_q;

	always_comb begin
		sts.operation   = req.operation;
		sts.is_reply    = (req.arp_opcode == ARP_OPCODE_REPLY);
		sts.pending     = pending_q;
		sts.sip_match   = (req.sender_ip == pending_ip_q);
		sts.tick_expire = (wait_inc >= limit);
		sts.sweep_done  = (left_q == '0);
		sts.cmp_valid   = cmp_valid_s1;
		sts.cmp_hit     = (rd_ip_s1 == key_q);
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("fill count above cache depth");

	a_wait_below_max: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> (wait_q != TICK_MAX))
		else $error("wait counter saturated while pending");

	a_sweep_left: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (left_q == $past(fill_q)))
		else $error("sweep did not load fill count");

endmodule

// ----- src/arc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_ctrl: controller of the arp reply cache
// decodes accepted words, runs the lookup sweep, owns response valid
// ----------------------------------------------------------------------------
module arc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  arc_pkg::sts_t sts,
	output arc_pkg::cmd_t cmd
);
	import arc_pkg::*;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   accept;

	assign req_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.out_status = ST_HIT;
		cmd.mac_sel    = MAC_ZERO;
		cmd.ip_sel     = IP_ZERO;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (sts.operation)
						OP_PACKET: begin
							if (sts.is_reply) begin
								cmd.store = 1'b1;
								if (sts.pending && sts.sip_match) begin
									cmd.clr_pending = 1'b1;
									cmd.out_load    = 1'b1;
									cmd.out_status  = ST_RESOLVED;
									cmd.mac_sel     = MAC_SENDER;
									cmd.ip_sel      = IP_SENDER;
								end
							end
						end
						OP_LOOKUP: begin
							if (sts.pending) begin
								cmd.out_load   = 1'b1;
								cmd.out_status = ST_BUSY;
							end else begin
								cmd.start = 1'b1;
								state_d   = S_SEARCH;
							end
						end
						OP_TICK: begin
							if (sts.pending) begin
								cmd.tick = 1'b1;
								if (sts.tick_expire) begin
									cmd.clr_pending = 1'b1;
									cmd.out_load    = 1'b1;
									cmd.out_status  = ST_TIMEOUT;
									cmd.ip_sel      = IP_PENDING;
								end
							end
						end
						default: ;
					endcase
				end
			end
			S_SEARCH: begin
				if (sts.cmp_valid && sts.cmp_hit) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = ST_HIT;
					cmd.mac_sel    = MAC_CACHE;
					cmd.ip_sel     = IP_KEY;
					state_d        = S_IDLE;
				end else if (sts.sweep_done && !sts.cmp_valid) begin
					cmd.set_pending = 1'b1;
					cmd.out_load    = 1'b1;
					cmd.out_status  = ST_MISS;
					cmd.ip_sel      = IP_KEY;
					state_d         = S_IDLE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp_valid_q || rsp_ready))
		else $error("response word overwritten before taken");

	a_search_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> !rsp_valid_q)
		else $error("response pending during sweep");

endmodule

// ----- src/arp_reply_cache_resolver_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_reply_cache_resolver_top: arp reply cache with one outstanding lookup
// stores arp replies newest first, resolves lookups by sweeping the cache
// ----------------------------------------------------------------------------
// resolving replies, expiring ticks, busy lookups: answer the cycle after acceptance
// lookup: hit on the newest matching entry, else miss once all filled entries swept,
//   paced by the sweep of one cache entry per cycle through the single read port
// a new word is taken once the previous one is done and the response slot frees
// reset: asynchronous, clears fill count, pointers, pending wait, timeout = 2000
// no clearing pass: the fill count marks which entries hold data
module arp_reply_cache_resolver_top #(
	parameter int CACHE_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	arc_req_if.sink    req,
	arc_rsp_if.source  rsp,
	arc_cfg_if.sink    cfg
);
	import arc_pkg::*;

	req_t req_word;
	rsp_t rsp_word;
	cmd_t cmd;
	sts_t sts;

	// request word packed for the datapath
	assign req_word.operation  = req.operation;
	assign req_word.arp_opcode = req.arp_opcode;
	assign req_word.sender_mac = req.sender_mac;
	assign req_word.sender_ip  = req.sender_ip;
	assign req_word.target_ip  = req.target_ip;

	// register writes are always accepted
	assign cfg.ready = 1'b1;

	// controller: decode, sweep sequencing, response valid
	arc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: entry memory, compare, pending wait, response word
	arc_dp #(
		.CACHE_DEPTH (CACHE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_word),
		.cmd       (cmd),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.sts       (sts),
		.rsp       (rsp_word)
	);

	// response word out
	assign rsp.status            = rsp_word.status;
	assign rsp.resolved_mac      = rsp_word.resolved_mac;
	assign rsp.request_target_ip = rsp_word.request_target_ip;

endmodule
